// ===== sv/hctm_pkg.sv =====
`timescale 1ns / 1ps

package hctm_pkg;

  // Table geometry and value range.
  localparam int NUM_CURVES = 4;
  localparam int MAX_POINTS = 8;
  localparam int FULL_SCALE = 9600;

  localparam int CURVE_W  = 2;
  localparam int POINT_W  = $clog2(MAX_POINTS);
  localparam int ADDR_W   = $clog2(NUM_CURVES * MAX_POINTS);
  localparam int COUNT_W  = $clog2(MAX_POINTS + 1);
  localparam int RANGE_W  = 15;
  localparam int DIV_W    = 32;
  localparam int DCNT_W   = $clog2(DIV_W);
  localparam int MODE_STEP = FULL_SCALE * 2 / NUM_CURVES;

  // Target RPM that marks a curve without governor.
  localparam logic [15:0] NO_RPM = 16'hFFFF;

  // Input transaction commands.
  localparam logic [2:0] CMD_RUN       = 3'd0;
  localparam logic [2:0] CMD_RPM_MEAS  = 3'd1;
  localparam logic [2:0] CMD_SET_NAV   = 3'd2;
  localparam logic [2:0] CMD_WR_POINT  = 3'd3;
  localparam logic [2:0] CMD_WR_COUNT  = 3'd4;

  // Pilot modes.
  localparam logic [1:0] PMODE_NAV      = 2'd1;
  localparam logic [1:0] PMODE_FAILSAFE = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_THROTTLE_TRIM   = 3'd0;
  localparam logic [2:0] REG_COLLECTIVE_TRIM = 3'd1;
  localparam logic [2:0] REG_RPM_P_GAIN      = 3'd2;
  localparam logic [2:0] REG_RPM_I_GAIN      = 3'd3;
  localparam logic [2:0] REG_RPM_STEP_LIMIT  = 3'd4;

  // Segment width for a curve of n points, looked up at index n-1.
  localparam logic [RANGE_W-1:0] RANGE_LUT [16] = '{
    RANGE_W'(0),
    RANGE_W'(FULL_SCALE / 1),  RANGE_W'(FULL_SCALE / 2),  RANGE_W'(FULL_SCALE / 3),
    RANGE_W'(FULL_SCALE / 4),  RANGE_W'(FULL_SCALE / 5),  RANGE_W'(FULL_SCALE / 6),
    RANGE_W'(FULL_SCALE / 7),  RANGE_W'(FULL_SCALE / 8),  RANGE_W'(FULL_SCALE / 9),
    RANGE_W'(FULL_SCALE / 10), RANGE_W'(FULL_SCALE / 11), RANGE_W'(FULL_SCALE / 12),
    RANGE_W'(FULL_SCALE / 13), RANGE_W'(FULL_SCALE / 14), RANGE_W'(FULL_SCALE / 15)
  };

  // One curve point as stored in the table memory.
  typedef struct packed {
    logic [13:0]        thr;
    logic signed [14:0] col;
    logic [15:0]        rpm;
  } point_t;

  localparam int POINT_BITS = $bits(point_t);

endpackage

// ===== sv/hctm_if.sv =====
`timescale 1ns / 1ps

// Input item channel.
interface hctm_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic [13:0]        thrust_cmd;
  logic signed [14:0] mode_switch;
  logic [1:0]         pilot_mode;
  logic               motors_on;
  logic [15:0]        rpm_value;
  logic [7:0]         curve_select;
  logic [2:0]         point_select;
  logic [13:0]        point_throttle;
  logic signed [14:0] point_collective;
  logic [15:0]        point_rpm;
  logic [3:0]         point_count;

  modport source (
    output valid, command, thrust_cmd, mode_switch, pilot_mode, motors_on, rpm_value,
           curve_select, point_select, point_throttle, point_collective, point_rpm,
           point_count,
    input  ready
  );
  modport sink (
    input  valid, command, thrust_cmd, mode_switch, pilot_mode, motors_on, rpm_value,
           curve_select, point_select, point_throttle, point_collective, point_rpm,
           point_count,
    output ready
  );
endinterface

// Result channel.
interface hctm_out_if;
  logic               valid;
  logic               ready;
  logic [13:0]        thrust_out;
  logic signed [14:0] collective_out;
  logic [15:0]        rpm_target;
  logic [1:0]         active_curve;

  modport source (
    output valid, thrust_out, collective_out, rpm_target, active_curve,
    input  ready
  );
  modport sink (
    input  valid, thrust_out, collective_out, rpm_target, active_curve,
    output ready
  );
endinterface

// Configuration write channel.
interface hctm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [15:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

// ===== sv/hctm_ram.sv =====
`timescale 1ns / 1ps

module hctm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/heli_throttle_curve_mixer.sv =====
`timescale 1ns / 1ps
// A run transaction steps through the point reads, the serial divisions and interpolation to
// the result register (a single-point curve skips the search and interpolation); table,
// measurement and mode transactions complete on acceptance. One transaction at a time: the next
// is accepted from the cycle after the result loads; the shared serial divider, used once for the
// segment and once per interpolated field, sets the run time.
// Reset: asynchronous, active low; clears control state, trims, gains and governor state,
// sets the RPM step limit to 1. The curve memory and point counts stay undefined.
module heli_throttle_curve_mixer (
  input  logic       clk_i,
  input  logic       rst_ni,
  hctm_in_if.sink    in_i,
  hctm_out_if.source out_o,
  hctm_cfg_if.sink   cfg_i
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD0  = 4'd1;
  localparam logic [3:0] ST_SDIV = 4'd2;
  localparam logic [3:0] ST_RA0  = 4'd3;
  localparam logic [3:0] ST_RA1  = 4'd4;
  localparam logic [3:0] ST_RB   = 4'd5;
  localparam logic [3:0] ST_MUL  = 4'd6;
  localparam logic [3:0] ST_LOAD = 4'd7;
  localparam logic [3:0] ST_LDIV = 4'd8;
  localparam logic [3:0] ST_RPM  = 4'd9;
  localparam logic [3:0] ST_TRIM = 4'd10;
  localparam logic [3:0] ST_GOV1 = 4'd11;
  localparam logic [3:0] ST_GOV2 = 4'd12;
  localparam logic [3:0] ST_GOV3 = 4'd13;
  localparam logic [3:0] ST_OUT  = 4'd14;

  localparam logic [1:0] FLD_THR = 2'd0;
  localparam logic [1:0] FLD_COL = 2'd1;
  localparam logic [1:0] FLD_RPM = 2'd2;

  localparam logic signed [33:0] FS34 = 34'(hctm_pkg::FULL_SCALE);

  function automatic logic signed [33:0] clamp34(input logic signed [33:0] v,
                                                 input logic signed [33:0] lo,
                                                 input logic signed [33:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Control and working registers.
  logic [3:0]                       state_q, state_d;
  logic [13:0]                      thrust_q, thrust_d;
  logic                             motors_q, motors_d;
  logic [1:0]                       mode_q, mode_d;
  logic [hctm_pkg::ADDR_W-1:0]      base_q, base_d;
  logic [hctm_pkg::ADDR_W-1:0]      addr_q, addr_d;
  logic                             has_rpm_q, has_rpm_d;
  logic [hctm_pkg::COUNT_W-1:0]     n_q, n_d;
  logic [hctm_pkg::RANGE_W-1:0]     range_q, range_d;
  logic [13:0]                      x_q, x_d;
  hctm_pkg::point_t                 pa_q, pa_d, pb_q, pb_d;
  logic [1:0]                       field_q, field_d;
  logic signed [32:0]               prod_q, prod_d;
  logic signed [33:0]               thr_q, thr_d, col_q, col_d, nr_q, nr_d;
  logic [hctm_pkg::DIV_W-1:0]       quo_q, quo_d;
  logic [hctm_pkg::RANGE_W-1:0]     rem_q, rem_d, div_q, div_d;
  logic [hctm_pkg::DCNT_W-1:0]      cnt_q, cnt_d;
  logic                             neg_q, neg_d;
  logic                             gov_q, gov_d;
  logic signed [32:0]               pi_q, pi_d, pp_q, pp_d;

  // Architectural state.
  logic [1:0]                       nav_q, nav_d;
  logic [15:0]                      sp_q, sp_d;
  logic [15:0]                      meas_q, meas_d;
  logic                             fresh_q, fresh_d;
  logic signed [23:0]               isum_q, isum_d;
  logic [hctm_pkg::COUNT_W-1:0]     counts_q [hctm_pkg::NUM_CURVES];
  logic                             cnt_we;
  logic [1:0]                       cnt_wsel;
  logic [hctm_pkg::COUNT_W-1:0]     cnt_wval;

  // Configuration registers.
  logic signed [14:0] thr_trim_q, col_trim_q;
  logic signed [15:0] p_gain_q, i_gain_q;
  logic [15:0]        step_lim_q;

  // Result register.
  logic        out_valid_q;
  logic [13:0] out_thr_q;
  logic [14:0] out_col_q;
  logic [15:0] out_rpm_q;
  logic [1:0]  out_curve_q;
  logic        out_load;

  // Curve memory ports.
  logic                        ram_we;
  logic [hctm_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  hctm_pkg::point_t            ram_wdata, ram_rdata;
  logic [hctm_pkg::POINT_BITS-1:0] ram_rraw;

  hctm_ram #(
    .WIDTH (hctm_pkg::POINT_BITS),
    .DEPTH (hctm_pkg::NUM_CURVES * hctm_pkg::MAX_POINTS)
  ) u_curve_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rraw)
  );

  assign ram_rdata = hctm_pkg::point_t'(ram_rraw);

  logic in_fire;
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  // Curve chosen for a run transaction.
  logic signed [16:0] sw_sum;
  logic [1:0]         mode_sel;
  logic [1:0]         sw_curve;
  always_comb begin
    sw_sum   = 17'(in_i.mode_switch) + 17'(hctm_pkg::FULL_SCALE);
    sw_curve = '0;
    for (int k = 1; k < hctm_pkg::NUM_CURVES; k++) begin
      if (!sw_sum[16] && (sw_sum >= $signed(17'(k * hctm_pkg::MODE_STEP)))) begin
        sw_curve = sw_curve + 2'd1;
      end
    end
    if (in_i.pilot_mode == hctm_pkg::PMODE_NAV) begin
      mode_sel = nav_q;
    end else if (in_i.pilot_mode == hctm_pkg::PMODE_FAILSAFE) begin
      mode_sel = '0;
    end else begin
      mode_sel = sw_curve;
    end
  end

  // Curve index of table transactions, clamped to the last curve.
  logic [1:0] csel;
  assign csel = (in_i.curve_select > 8'(hctm_pkg::NUM_CURVES - 1)) ?
                2'(hctm_pkg::NUM_CURVES - 1) : in_i.curve_select[1:0];

  logic [hctm_pkg::ADDR_W-1:0] sel_base;
  assign sel_base = hctm_pkg::ADDR_W'(int'(mode_sel) * hctm_pkg::MAX_POINTS);

  // Point writes go straight to memory.
  always_comb begin
    ram_we    = in_fire && (in_i.command == hctm_pkg::CMD_WR_POINT) &&
                (int'(in_i.point_select) < hctm_pkg::MAX_POINTS);
    ram_waddr = hctm_pkg::ADDR_W'(int'(csel) * hctm_pkg::MAX_POINTS +
                                  int'(in_i.point_select));
    ram_wdata = '{thr: in_i.point_throttle, col: in_i.point_collective,
                  rpm: in_i.point_rpm};
    ram_raddr = (state_q == ST_IDLE) ? sel_base : addr_q;
  end

  // Serial restoring divider, one quotient bit per cycle.
  logic [hctm_pkg::RANGE_W:0]   rem_sh;
  logic                         div_ge;
  logic [hctm_pkg::RANGE_W-1:0] rem_n;
  logic [hctm_pkg::DIV_W-1:0]   quo_n;
  always_comb begin
    rem_sh = {rem_q, quo_q[hctm_pkg::DIV_W-1]};
    div_ge = rem_sh >= {1'b0, div_q};
    rem_n  = div_ge ? hctm_pkg::RANGE_W'(rem_sh - {1'b0, div_q})
                    : rem_sh[hctm_pkg::RANGE_W-1:0];
    quo_n  = {quo_q[hctm_pkg::DIV_W-2:0], div_ge};
  end

  // Endpoints of the field being interpolated.
  logic signed [17:0] a_v, b_v;
  always_comb begin
    case (field_q)
      FLD_THR: begin
        a_v = $signed({4'b0, pa_q.thr});
        b_v = $signed({4'b0, pb_q.thr});
      end
      FLD_COL: begin
        a_v = 18'(pa_q.col);
        b_v = 18'(pb_q.col);
      end
      default: begin
        a_v = $signed({2'b0, pa_q.rpm});
        b_v = $signed({2'b0, pb_q.rpm});
      end
    endcase
  end

  // Scratch values for the sequencer.
  logic [hctm_pkg::COUNT_W-1:0]         n_cur, n_lim;
  logic [hctm_pkg::COUNT_W-1:0]         n_m1;
  logic [hctm_pkg::POINT_W-1:0]         p_seg;
  logic [hctm_pkg::POINT_W+hctm_pkg::RANGE_W-1:0] p_off;
  logic signed [33:0]                   q_s, lerp_res;
  logic signed [32:0]                   prod_mag;
  logic [15:0]                          sp_base, nr_c;
  logic signed [16:0]                   rpm_dd, rpm_lim, err;
  logic signed [17:0]                   sp_sum;
  logic signed [32:0]                   inc, pi_adj;
  logic signed [33:0]                   isum_sum, lo_b, hi_b;
  logic signed [34:0]                   fb_sum, fb_adj, fb_raw;
  logic signed [33:0]                   fb_c;

  always_comb begin
    state_d   = state_q;
    thrust_d  = thrust_q;
    motors_d  = motors_q;
    mode_d    = mode_q;
    base_d    = base_q;
    addr_d    = addr_q;
    has_rpm_d = has_rpm_q;
    n_d       = n_q;
    range_d   = range_q;
    x_d       = x_q;
    pa_d      = pa_q;
    pb_d      = pb_q;
    field_d   = field_q;
    prod_d    = prod_q;
    thr_d     = thr_q;
    col_d     = col_q;
    nr_d      = nr_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    div_d     = div_q;
    cnt_d     = cnt_q;
    neg_d     = neg_q;
    gov_d     = gov_q;
    pi_d      = pi_q;
    pp_d      = pp_q;
    nav_d     = nav_q;
    sp_d      = sp_q;
    meas_d    = meas_q;
    fresh_d   = fresh_q;
    isum_d    = isum_q;
    cnt_we    = 1'b0;
    cnt_wsel  = csel;
    cnt_wval  = '0;
    out_load  = 1'b0;

    n_cur    = counts_q[mode_q];
    n_m1     = n_cur - hctm_pkg::COUNT_W'(1);
    n_lim    = n_q - hctm_pkg::COUNT_W'(2);
    p_seg    = (quo_n > hctm_pkg::DIV_W'(n_lim)) ? n_lim[hctm_pkg::POINT_W-1:0]
                                                 : quo_n[hctm_pkg::POINT_W-1:0];
    p_off    = p_seg * range_q;
    prod_mag = prod_q[32] ? -prod_q : prod_q;
    q_s      = neg_q ? -$signed({2'b0, quo_n}) : $signed({2'b0, quo_n});
    lerp_res = 34'(a_v) + q_s;

    sp_base  = (sp_q == hctm_pkg::NO_RPM) ? meas_q : sp_q;
    nr_c     = 16'(clamp34(nr_q, 34'sd0, 34'sd65535));
    rpm_dd   = $signed({1'b0, nr_c}) - $signed({1'b0, sp_base});
    rpm_lim  = $signed({1'b0, step_lim_q});
    if (rpm_dd > rpm_lim) begin
      rpm_dd = rpm_lim;
    end else if (rpm_dd < -rpm_lim) begin
      rpm_dd = -rpm_lim;
    end
    sp_sum   = $signed({2'b0, sp_base}) + 18'(rpm_dd);

    err      = $signed({1'b0, sp_q}) - $signed({1'b0, meas_q});
    pi_adj   = pi_q + (pi_q[32] ? 33'sd511 : 33'sd0);
    inc      = pi_adj >>> 9;
    isum_sum = 34'(isum_q) + 34'(inc);
    lo_b     = -(thr_q <<< 8);
    hi_b     = (FS34 - thr_q) <<< 8;
    fb_sum   = 35'(pp_q) + 35'(isum_q);
    fb_adj   = fb_sum + (fb_sum[34] ? 35'sd255 : 35'sd0);
    fb_raw   = fb_adj >>> 8;
    if (fb_raw > 35'(FS34)) begin
      fb_c = FS34;
    end else if (fb_raw < -35'(FS34)) begin
      fb_c = -FS34;
    end else begin
      fb_c = 34'(fb_raw);
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_i.command)
            hctm_pkg::CMD_RUN: begin
              thrust_d = in_i.thrust_cmd;
              motors_d = in_i.motors_on;
              mode_d   = mode_sel;
              base_d   = sel_base;
              state_d  = ST_RD0;
            end
            hctm_pkg::CMD_RPM_MEAS: begin
              meas_d  = in_i.rpm_value;
              fresh_d = 1'b1;
            end
            hctm_pkg::CMD_SET_NAV: begin
              nav_d = csel;
            end
            hctm_pkg::CMD_WR_COUNT: begin
              cnt_we = 1'b1;
              if (in_i.point_count == 4'd0) begin
                cnt_wval = hctm_pkg::COUNT_W'(1);
              end else if (int'(in_i.point_count) > hctm_pkg::MAX_POINTS) begin
                cnt_wval = hctm_pkg::COUNT_W'(hctm_pkg::MAX_POINTS);
              end else begin
                cnt_wval = hctm_pkg::COUNT_W'(in_i.point_count);
              end
            end
            default: begin
            end
          endcase
        end
      end
      // Point 0 is here; decide single point or segment search.
      ST_RD0: begin
        pa_d      = ram_rdata;
        has_rpm_d = ram_rdata.rpm != hctm_pkg::NO_RPM;
        n_d       = n_cur;
        if (n_cur <= hctm_pkg::COUNT_W'(1)) begin
          thr_d   = $signed({20'b0, ram_rdata.thr});
          col_d   = 34'(ram_rdata.col);
          sp_d    = ram_rdata.rpm;
          state_d = ST_TRIM;
        end else begin
          range_d = hctm_pkg::RANGE_LUT[n_m1[3:0]];
          div_d   = hctm_pkg::RANGE_LUT[n_m1[3:0]];
          quo_d   = hctm_pkg::DIV_W'(thrust_q);
          rem_d   = '0;
          cnt_d   = hctm_pkg::DCNT_W'(hctm_pkg::DIV_W - 1);
          state_d = ST_SDIV;
        end
      end
      // Segment index: thrust divided by the segment width.
      ST_SDIV: begin
        quo_d = quo_n;
        rem_d = rem_n;
        cnt_d = cnt_q - hctm_pkg::DCNT_W'(1);
        if (cnt_q == '0) begin
          x_d     = 14'(thrust_q - 14'(p_off));
          addr_d  = base_q + hctm_pkg::ADDR_W'(p_seg);
          state_d = ST_RA0;
        end
      end
      ST_RA0: begin
        addr_d  = addr_q + hctm_pkg::ADDR_W'(1);
        state_d = ST_RA1;
      end
      ST_RA1: begin
        pa_d    = ram_rdata;
        state_d = ST_RB;
      end
      ST_RB: begin
        pb_d    = ram_rdata;
        field_d = FLD_THR;
        state_d = ST_MUL;
      end
      // Interpolation product of the current field.
      ST_MUL: begin
        prod_d  = (b_v - a_v) * $signed({1'b0, x_q});
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        neg_d   = prod_q[32];
        quo_d   = prod_mag[hctm_pkg::DIV_W-1:0];
        rem_d   = '0;
        div_d   = range_q;
        cnt_d   = hctm_pkg::DCNT_W'(hctm_pkg::DIV_W - 1);
        state_d = ST_LDIV;
      end
      // Division toward zero, then add the left endpoint.
      ST_LDIV: begin
        quo_d = quo_n;
        rem_d = rem_n;
        cnt_d = cnt_q - hctm_pkg::DCNT_W'(1);
        if (cnt_q == '0) begin
          case (field_q)
            FLD_THR: thr_d = lerp_res;
            FLD_COL: col_d = lerp_res;
            default: nr_d  = lerp_res;
          endcase
          if (field_q == FLD_RPM) begin
            state_d = ST_RPM;
          end else begin
            field_d = field_q + 2'd1;
            state_d = ST_MUL;
          end
        end
      end
      // Slew the RPM target toward the curve.
      ST_RPM: begin
        if (has_rpm_q) begin
          sp_d = 16'(clamp34(34'(sp_sum), 34'sd0, 34'sd65535));
        end else begin
          sp_d = hctm_pkg::NO_RPM;
        end
        state_d = ST_TRIM;
      end
      ST_TRIM: begin
        thr_d   = clamp34(thr_q + 34'(thr_trim_q), 34'sd0, FS34);
        col_d   = clamp34(col_q + 34'(col_trim_q), -FS34, FS34);
        state_d = ST_GOV1;
      end
      // Governor products.
      ST_GOV1: begin
        gov_d   = has_rpm_q && fresh_q;
        pi_d    = err * i_gain_q;
        pp_d    = err * p_gain_q;
        state_d = ST_GOV2;
      end
      // Integral update with anti-windup bounds.
      ST_GOV2: begin
        if (gov_q) begin
          isum_d = 24'(clamp34(isum_sum, lo_b, hi_b));
        end else if (!has_rpm_q) begin
          isum_d = '0;
        end
        state_d = ST_GOV3;
      end
      // Feedback onto throttle, then the motors-off override.
      ST_GOV3: begin
        if (gov_q) begin
          thr_d   = clamp34(thr_q + fb_c, 34'sd0, FS34);
          fresh_d = 1'b0;
        end
        if (!motors_q) begin
          thr_d  = '0;
          isum_d = '0;
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and architectural registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      nav_q       <= '0;
      sp_q        <= '0;
      meas_q      <= '0;
      fresh_q     <= 1'b0;
      isum_q      <= '0;
      out_valid_q <= 1'b0;
      thr_trim_q  <= '0;
      col_trim_q  <= '0;
      p_gain_q    <= '0;
      i_gain_q    <= '0;
      step_lim_q  <= 16'd1;
    end else begin
      state_q <= state_d;
      nav_q   <= nav_d;
      sp_q    <= sp_d;
      meas_q  <= meas_d;
      fresh_q <= fresh_d;
      isum_q  <= isum_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        case (cfg_i.reg_index)
          hctm_pkg::REG_THROTTLE_TRIM:   thr_trim_q <= $signed(cfg_i.wdata[14:0]);
          hctm_pkg::REG_COLLECTIVE_TRIM: col_trim_q <= $signed(cfg_i.wdata[14:0]);
          hctm_pkg::REG_RPM_P_GAIN:      p_gain_q   <= $signed(cfg_i.wdata);
          hctm_pkg::REG_RPM_I_GAIN:      i_gain_q   <= $signed(cfg_i.wdata);
          hctm_pkg::REG_RPM_STEP_LIMIT:  step_lim_q <= cfg_i.wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk_i) begin
    thrust_q  <= thrust_d;
    motors_q  <= motors_d;
    mode_q    <= mode_d;
    base_q    <= base_d;
    addr_q    <= addr_d;
    has_rpm_q <= has_rpm_d;
    n_q       <= n_d;
    range_q   <= range_d;
    x_q       <= x_d;
    pa_q      <= pa_d;
    pb_q      <= pb_d;
    field_q   <= field_d;
    prod_q    <= prod_d;
    thr_q     <= thr_d;
    col_q     <= col_d;
    nr_q      <= nr_d;
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    div_q     <= div_d;
    cnt_q     <= cnt_d;
    neg_q     <= neg_d;
    gov_q     <= gov_d;
    pi_q      <= pi_d;
    pp_q      <= pp_d;
    if (cnt_we) begin
      counts_q[cnt_wsel] <= cnt_wval;
    end
    if (out_load) begin
      out_thr_q   <= thr_q[13:0];
      out_col_q   <= col_q[14:0];
      out_rpm_q   <= sp_q;
      out_curve_q <= mode_q;
    end
  end

  assign cfg_i.ready          = 1'b1;
  assign out_o.valid          = out_valid_q;
  assign out_o.thrust_out     = out_thr_q;
  assign out_o.collective_out = $signed(out_col_q);
  assign out_o.rpm_target     = out_rpm_q;
  assign out_o.active_curve   = out_curve_q;

endmodule

// ===== dv/hctm_checker.sv =====
`timescale 1ns / 1ps

// Watches the three channels of the mixer, predicts each run result and compares it
// field by field with what the block returns.
module hctm_checker (
  input  logic clk_i,
  input  logic rst_ni,
  hctm_in_if   in_mon,
  hctm_out_if  out_mon,
  hctm_cfg_if  cfg_mon,
  output int   fail_count,
  output int   pending_count
);

  typedef struct packed {
    logic [13:0]        thr;
    logic signed [14:0] col;
    logic [15:0]        rpm;
    logic [1:0]         curve;
  } mix_result_t;

  mix_result_t expected_mix[$];

  // Shadow copy of the curve table and the governor state.
  logic [13:0]        thr_tab [hctm_pkg::NUM_CURVES*hctm_pkg::MAX_POINTS];
  logic signed [14:0] col_tab [hctm_pkg::NUM_CURVES*hctm_pkg::MAX_POINTS];
  logic [15:0]        rpm_tab [hctm_pkg::NUM_CURVES*hctm_pkg::MAX_POINTS];
  logic [3:0]         cnt_tab [hctm_pkg::NUM_CURVES];
  logic [1:0]         nav_sel;
  logic [15:0]        rpm_set;
  logic [15:0]        rpm_sample;
  bit                 meas_fresh;
  longint             integ_acc;

  // Shadow copy of the configuration registers.
  logic signed [14:0] thr_trim;
  logic signed [14:0] col_trim;
  logic signed [15:0] p_gain;
  logic signed [15:0] i_gain;
  logic [15:0]        step_lim;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint interp(longint a, longint b, longint x, longint rng);
    return a + ((b - a) * x) / rng;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Applies one accepted input transaction to the shadow state; a run step yields a result.
  task automatic mix_step(output bit produced, output mix_result_t res);
    int     csel;
    int     k;
    int     mode;
    int     base;
    int     a;
    longint n, rng, p, x, thr, col, s, nr, d, err, fb, ra, rb, ta, tb, ca, cb;
    bit     has_rpm;
    produced = 0;
    res = '0;
    csel = (in_mon.curve_select > hctm_pkg::NUM_CURVES - 1) ? hctm_pkg::NUM_CURVES - 1
                                                             : int'(in_mon.curve_select);
    case (in_mon.command)
      hctm_pkg::CMD_RPM_MEAS: begin
        rpm_sample = in_mon.rpm_value;
        meas_fresh = 1;
      end
      hctm_pkg::CMD_SET_NAV: nav_sel = csel[1:0];
      hctm_pkg::CMD_WR_POINT: begin
        k = csel * hctm_pkg::MAX_POINTS + int'(in_mon.point_select);
        thr_tab[k] = in_mon.point_throttle;
        col_tab[k] = in_mon.point_collective;
        rpm_tab[k] = in_mon.point_rpm;
      end
      hctm_pkg::CMD_WR_COUNT:
        cnt_tab[csel] = 4'(clamp(longint'(in_mon.point_count), 1, hctm_pkg::MAX_POINTS));
      hctm_pkg::CMD_RUN: begin
        produced = 1;
        if (in_mon.pilot_mode == hctm_pkg::PMODE_NAV) begin
          mode = nav_sel;
        end else begin
          s = longint'(in_mon.mode_switch) + hctm_pkg::FULL_SCALE;
          mode = int'(clamp((s < 0) ? 0 : s / hctm_pkg::MODE_STEP, 0,
                            hctm_pkg::NUM_CURVES - 1));
        end
        if (in_mon.pilot_mode == hctm_pkg::PMODE_FAILSAFE) mode = 0;
        base = mode * hctm_pkg::MAX_POINTS;
        n = cnt_tab[mode];
        has_rpm = rpm_tab[base] != hctm_pkg::NO_RPM;
        if (n <= 1) begin
          thr = thr_tab[base];
          col = col_tab[base];
          rpm_set = rpm_tab[base];
        end else begin
          rng = hctm_pkg::FULL_SCALE / (n - 1);
          p = clamp(longint'(in_mon.thrust_cmd) / rng, 0, n - 2);
          x = longint'(in_mon.thrust_cmd) - p * rng;
          a = base + int'(p);
          ta = thr_tab[a];
          tb = thr_tab[a+1];
          ca = col_tab[a];
          cb = col_tab[a+1];
          thr = interp(ta, tb, x, rng);
          col = interp(ca, cb, x, rng);
          if (has_rpm) begin
            if (rpm_set == hctm_pkg::NO_RPM) rpm_set = rpm_sample;
            ra = rpm_tab[a];
            rb = rpm_tab[a+1];
            nr = clamp(interp(ra, rb, x, rng), 0, 65535);
            d = clamp(nr - longint'(rpm_set), -longint'(step_lim), longint'(step_lim));
            rpm_set = 16'(clamp(longint'(rpm_set) + d, 0, 65535));
          end else begin
            rpm_set = hctm_pkg::NO_RPM;
          end
        end
        thr = clamp(thr + longint'(thr_trim), 0, hctm_pkg::FULL_SCALE);
        col = clamp(col + longint'(col_trim), -hctm_pkg::FULL_SCALE, hctm_pkg::FULL_SCALE);
        // PI governor on a fresh measurement; a curve without RPM control drops the integral.
        if (has_rpm && meas_fresh) begin
          err = longint'(rpm_set) - longint'(rpm_sample);
          integ_acc += (err * longint'(i_gain)) / 512;
          integ_acc = clamp(integ_acc, -thr * 256, (hctm_pkg::FULL_SCALE - thr) * 256);
          fb = clamp((err * longint'(p_gain) + integ_acc) / 256, -hctm_pkg::FULL_SCALE,
                     hctm_pkg::FULL_SCALE);
          thr = clamp(thr + fb, 0, hctm_pkg::FULL_SCALE);
          meas_fresh = 0;
        end else if (!has_rpm) begin
          integ_acc = 0;
        end
        if (!in_mon.motors_on) begin
          thr = 0;
          integ_acc = 0;
        end
        res.thr = 14'(thr);
        res.col = 15'(col);
        res.rpm = rpm_set;
        res.curve = 2'(mode);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    mix_result_t got;
    mix_result_t want;
    mix_result_t res;
    bit          produced;
    if (!rst_ni) begin
      nav_sel = '0;
      rpm_set = '0;
      rpm_sample = '0;
      meas_fresh = 0;
      integ_acc = 0;
      thr_trim = '0;
      col_trim = '0;
      p_gain = '0;
      i_gain = '0;
      step_lim = 16'd1;
      expected_mix.delete();
      pending_count = 0;
    end else begin
      // Result transaction: compare with the oldest prediction.
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.thrust_out, out_mon.collective_out, out_mon.rpm_target,
                out_mon.active_curve};
        if (expected_mix.size() == 0) begin
          report_mismatch("result transaction count", 1, 0);
        end else begin
          want = expected_mix.pop_front();
          if (got.thr != want.thr) report_mismatch("thrust_out", got.thr, want.thr);
          if (got.col != want.col) report_mismatch("collective_out", got.col, want.col);
          if (got.rpm != want.rpm) report_mismatch("rpm_target", got.rpm, want.rpm);
          if (got.curve != want.curve) report_mismatch("active_curve", got.curve, want.curve);
        end
      end
      // Configuration write.
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.reg_index)
          hctm_pkg::REG_THROTTLE_TRIM:   thr_trim = cfg_mon.wdata[14:0];
          hctm_pkg::REG_COLLECTIVE_TRIM: col_trim = cfg_mon.wdata[14:0];
          hctm_pkg::REG_RPM_P_GAIN:      p_gain = cfg_mon.wdata;
          hctm_pkg::REG_RPM_I_GAIN:      i_gain = cfg_mon.wdata;
          hctm_pkg::REG_RPM_STEP_LIMIT:  step_lim = cfg_mon.wdata;
          default: ;
        endcase
      end
      // Input transaction.
      if (in_mon.valid && in_mon.ready) begin
        mix_step(produced, res);
        if (produced) expected_mix.push_back(res);
      end
      pending_count = expected_mix.size();
    end
  end

  initial fail_count = 0;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the throttle curve mixer; checking lives in hctm_checker.
module testbench;

  localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI  = 3'd7;
  localparam logic [1:0] PMODE_MANUAL  = 2'd0;
  localparam logic [1:0] PMODE_SPARE   = 2'd3;
  localparam int         SETTLE_CYCLES = 300;
  localparam int         CYCLE_LIMIT   = 3000000;
  localparam int         PHASE_ITEMS   = 233;

  typedef struct packed {
    logic [2:0]         command;
    logic [13:0]        thrust_cmd;
    logic signed [14:0] mode_switch;
    logic [1:0]         pilot_mode;
    logic               motors_on;
    logic [15:0]        rpm_value;
    logic [7:0]         curve_select;
    logic [2:0]         point_select;
    logic [13:0]        point_throttle;
    logic signed [14:0] point_collective;
    logic [15:0]        point_rpm;
    logic [3:0]         point_count;
  } mixer_item_t;

  localparam int ITEM_BITS = $bits(mixer_item_t);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   send_idle = 0;
  int   recv_idle = 0;
  int   hold_left = 0;
  int   fail_count;
  int   pending_count;
  int   cycle_count = 0;

  hctm_in_if  in_ch ();
  hctm_out_if out_ch ();
  hctm_cfg_if cfg_ch ();

  heli_throttle_curve_mixer DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  hctm_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_mon      (cfg_ch),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: random stalls, plus a long hold-off when requested.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = $urandom_range(0, 99) >= recv_idle;
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("heli_throttle_curve_mixer regression: fail");
    $finish;
  end

  task automatic send_item(mixer_item_t it);
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    {in_ch.command, in_ch.thrust_cmd, in_ch.mode_switch, in_ch.pilot_mode, in_ch.motors_on,
     in_ch.rpm_value, in_ch.curve_select, in_ch.point_select, in_ch.point_throttle,
     in_ch.point_collective, in_ch.point_rpm, in_ch.point_count} = it;
    in_ch.valid = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    in_ch.valid = 1'b0;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_ch.reg_index = idx;
    cfg_ch.wdata = val;
    cfg_ch.valid = 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  // Waits until every predicted result has come and the block has settled.
  task automatic drain();
    while (pending_count != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_all(int tt, int ct, int pg, int ig, int sl);
    write_reg(hctm_pkg::REG_THROTTLE_TRIM, 16'(tt));
    write_reg(hctm_pkg::REG_COLLECTIVE_TRIM, 16'(ct));
    write_reg(hctm_pkg::REG_RPM_P_GAIN, 16'(pg));
    write_reg(hctm_pkg::REG_RPM_I_GAIN, 16'(ig));
    write_reg(hctm_pkg::REG_RPM_STEP_LIMIT, 16'(sl));
  endtask

  function automatic mixer_item_t noise_item();
    mixer_item_t it;
    it = ITEM_BITS'({$urandom, $urandom, $urandom, $urandom});
    return it;
  endfunction

  function automatic mixer_item_t run_item(int thrust, int sw, logic [1:0] pm, bit on);
    mixer_item_t it;
    it = noise_item();
    it.command = hctm_pkg::CMD_RUN;
    it.thrust_cmd = 14'(thrust);
    it.mode_switch = 15'(sw);
    it.pilot_mode = pm;
    it.motors_on = on;
    return it;
  endfunction

  function automatic mixer_item_t point_item(int c, int p, int thr, int col, int rpm);
    mixer_item_t it;
    it = noise_item();
    it.command = hctm_pkg::CMD_WR_POINT;
    it.curve_select = 8'(c);
    it.point_select = 3'(p);
    it.point_throttle = 14'(thr);
    it.point_collective = 15'(col);
    it.point_rpm = 16'(rpm);
    return it;
  endfunction

  function automatic mixer_item_t ctrl_item(logic [2:0] cmd, int c, int val);
    mixer_item_t it;
    it = noise_item();
    it.command = cmd;
    it.curve_select = 8'(c);
    it.point_count = 4'(val);
    it.rpm_value = 16'(val);
    return it;
  endfunction

  // Random transaction, shaped toward measurement then run pairs on written curves.
  task automatic send_random();
    mixer_item_t it;
    int          pick;
    it = noise_item();
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      it.command = hctm_pkg::CMD_RPM_MEAS;
      if ($urandom_range(0, 1)) it.rpm_value = 16'($urandom_range(0, 4000));
      send_item(it);
      it = noise_item();
      pick = 0;
    end
    if (pick < 70) begin
      it.command = hctm_pkg::CMD_RUN;
      if ($urandom_range(0, 9) != 0) begin
        it.thrust_cmd = 14'($urandom_range(0, hctm_pkg::FULL_SCALE));
      end
      if ($urandom_range(0, 9) != 0) it.motors_on = 1'b1;
    end else if (pick < 75) begin
      it.command = hctm_pkg::CMD_SET_NAV;
    end else if (pick < 88) begin
      it.command = hctm_pkg::CMD_WR_POINT;
      if ($urandom_range(0, 3) != 0) begin
        it.point_throttle = 14'($urandom_range(0, hctm_pkg::FULL_SCALE));
      end
      if ($urandom_range(0, 3) != 0) it.point_rpm = 16'($urandom_range(0, 4000));
      else if ($urandom_range(0, 2) == 0) it.point_rpm = hctm_pkg::NO_RPM;
    end else if (pick < 96) begin
      it.command = hctm_pkg::CMD_WR_COUNT;
    end else begin
      it.command = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    end
    send_item(it);
  endtask

  initial begin
    {in_ch.command, in_ch.thrust_cmd, in_ch.mode_switch, in_ch.pilot_mode, in_ch.motors_on,
     in_ch.rpm_value, in_ch.curve_select, in_ch.point_select, in_ch.point_throttle,
     in_ch.point_collective, in_ch.point_rpm, in_ch.point_count} = '0;
    in_ch.valid = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = hctm_pkg::REG_THROTTLE_TRIM;
    cfg_ch.wdata = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Fill the whole table so no run reads an unwritten entry.
    for (int c = 0; c < hctm_pkg::NUM_CURVES; c++) begin
      for (int p = 0; p < hctm_pkg::MAX_POINTS; p++) begin
        send_item(point_item(c, p, p * 1200, p * 2400 - 9600, 1000 + p * 300 + c * 50));
      end
      send_item(ctrl_item(hctm_pkg::CMD_WR_COUNT, c, hctm_pkg::MAX_POINTS));
    end
    write_all(0, 0, 256, 64, 50);

    // Directed corners.
    send_item(run_item(0, -9600, PMODE_MANUAL, 1));
    send_item(run_item(hctm_pkg::FULL_SCALE, 9600, PMODE_MANUAL, 1));
    send_item(run_item(16383, 16383, PMODE_MANUAL, 1));
    send_item(run_item(4800, -16384, PMODE_SPARE, 1));
    send_item(ctrl_item(hctm_pkg::CMD_RPM_MEAS, 0, 65535));
    send_item(run_item(1234, 0, hctm_pkg::PMODE_FAILSAFE, 1));
    send_item(ctrl_item(hctm_pkg::CMD_SET_NAV, 255, 0));
    send_item(ctrl_item(hctm_pkg::CMD_RPM_MEAS, 0, 0));
    send_item(run_item(7000, 0, hctm_pkg::PMODE_NAV, 1));
    send_item(run_item(7000, 0, hctm_pkg::PMODE_NAV, 0));
    // Curve 2 without RPM control, then a single-point curve 1 and clamped counts.
    send_item(point_item(2, 0, 16383, 16383, hctm_pkg::NO_RPM));
    send_item(run_item(9000, 3000, PMODE_MANUAL, 1));
    send_item(ctrl_item(hctm_pkg::CMD_WR_COUNT, 1, 1));
    send_item(run_item(500, -2000, PMODE_MANUAL, 1));
    send_item(ctrl_item(hctm_pkg::CMD_WR_COUNT, 1, 0));
    send_item(point_item(1, 0, 0, -16384, 0));
    send_item(run_item(500, -2000, PMODE_MANUAL, 1));
    send_item(ctrl_item(hctm_pkg::CMD_WR_COUNT, 3, 15));
    send_item(ctrl_item(hctm_pkg::CMD_WR_COUNT, 0, 2));
    send_item(ctrl_item(hctm_pkg::CMD_RPM_MEAS, 0, 900));
    send_item(run_item(16383, 0, hctm_pkg::PMODE_FAILSAFE, 1));
    send_item(ctrl_item(CMD_SPARE_LO, 0, 0));
    send_item(ctrl_item(CMD_SPARE_HI, 0, 0));
    send_item(run_item(9600, 9600, PMODE_MANUAL, 1));

    // Random phases, each with its own register setting; successive pairs of phases share an idle pattern.
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: write_all(0, 0, 256, 16, 100);
        1: write_all(9600, -9600, 32767, 32767, 65535);
        2: write_all(-9600, 9600, -32768, -32768, 0);
        4: write_all(0, 0, 128, 64, 500);
        default: write_all($urandom_range(0, 19200) - 9600, $urandom_range(0, 19200) - 9600,
                           $urandom, $urandom, $urandom);
      endcase
      send_idle = (ph < 2) ? 34 : ((ph < 4) ? 61 : 0);
      recv_idle = (ph < 2) ? 61 : ((ph < 4) ? 34 : 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == 100) hold_left = 3000;
        // Sender pause until the block has caught up.
        if (ph == 3 && n == 150) begin
          while (pending_count != 0) @(negedge clk_i);
        end
        send_random();
      end
    end

    drain();
    if (fail_count == 0 && pending_count == 0) begin
      $display("heli_throttle_curve_mixer regression: pass");
    end else begin
      $display("heli_throttle_curve_mixer regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/hctm_pkg.sv
sv/hctm_if.sv
sv/hctm_ram.sv
sv/heli_throttle_curve_mixer.sv
dv/hctm_checker.sv
dv/testbench.sv
